/* design/sqb_pkg.sv */
// sqb_pkg: shared types and codes for the stack / queue buffer
// no dependencies; imported by sqb_front, sqb_back and stack_queue_buffer
`default_nettype none

package sqb_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef enum logic [1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_PEEK = 2'd2,
        ACT_DUMP = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    typedef struct packed {
        t_action                    action;
        logic signed [VALUE_W-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_q;

endpackage

`default_nettype wire

/* design/sqb_front.sv */
// sqb_front: input side of the buffer, takes beats and decodes them into commands
// holds a two-entry command queue toward sqb_back; uses sqb_pkg
`default_nettype none

module sqb_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [1:0]                 i_action,
    input  wire logic [sqb_pkg::VALUE_W-1:0] i_value,
    input  wire logic                       i_pop,
    output sqb_pkg::t_cmd_q                 o_q
);
    import sqb_pkg::*;

    t_cmd       r_ent [0:1];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    logic       pop;
    t_cmd       in_cmd;

    assign o_ready       = (r_cnt != 2'd2);
    assign o_q.valid     = (r_cnt != 2'd0);
    assign o_q.cmd       = r_ent[r_rd];
    assign push          = i_valid && o_ready;
    assign pop           = i_pop && o_q.valid;
    assign in_cmd.action = t_action'(i_action);
    assign in_cmd.value  = i_value;

    always_comb begin
        n_wr  = push ? ~r_wr : r_wr;
        n_rd  = pop ? ~r_rd : r_rd;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wr] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

/* design/sqb_back.sv */
// sqb_back: executes commands against the circular element store
// owns the element memory, front index, count, mode and result register; uses sqb_pkg
`default_nettype none

module sqb_back #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    input  wire logic                        i_cfg_data,
    input  wire sqb_pkg::t_cmd_q             i_q,
    output logic                             o_pop,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [sqb_pkg::VALUE_W-1:0]      o_data,
    output logic                             o_has_data,
    output sqb_pkg::t_status                 o_status,
    output logic                             o_last
);
    import sqb_pkg::*;

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CW + 1;

    logic signed [VALUE_W-1:0] r_mem [0:DEPTH-1];
    logic signed [VALUE_W-1:0] r_rd_data;

    t_state           r_state, n_state;
    logic [IW-1:0]    r_front, n_front;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_left, n_left;
    logic [CW-1:0]    r_off, n_off;
    logic             r_queue_mode;
    logic             r_out_valid, n_out_valid;
    logic [VALUE_W-1:0] r_out_data, n_out_data;
    logic             r_out_has, n_out_has;
    t_status          r_out_status, n_out_status;
    logic             r_out_last, n_out_last;

    logic             out_free;
    logic             we;
    logic [IW-1:0]    waddr;
    logic             re;
    logic [IW-1:0]    raddr;

    function automatic logic [IW-1:0] slot(input logic [IW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state      = r_state;
        n_front      = r_front;
        n_count      = r_count;
        n_left       = r_left;
        n_off        = r_off;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_data   = r_out_data;
        n_out_has    = r_out_has;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        we           = 1'b0;
        waddr        = r_front;
        re           = 1'b0;
        raddr        = r_front;
        o_pop        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q.valid && out_free) begin
                    o_pop        = 1'b1;
                    n_out_data   = '0;
                    n_out_has    = 1'b0;
                    n_out_status = ST_OK;
                    n_out_last   = 1'b1;
                    unique case (i_q.cmd.action)
                        ACT_PUSH: begin
                            n_out_valid = 1'b1;
                            if (r_count >= CW'(DEPTH)) begin
                                n_out_status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                n_count = r_count + CW'(1);
                                if (r_queue_mode) begin
                                    waddr = slot(r_front, r_count);
                                end else begin
                                    n_front = (r_front == '0) ? IW'(DEPTH - 1)
                                                              : r_front - IW'(1);
                                    waddr   = n_front;
                                end
                            end
                        end
                        ACT_POP: begin
                            n_out_valid = 1'b1;
                            if (r_count == '0) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_front = slot(r_front, CW'(1));
                                n_count = r_count - CW'(1);
                            end
                        end
                        ACT_PEEK: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_status = ST_EMPTY;
                            end else begin
                                re      = 1'b1;
                                n_left  = '0;
                                n_off   = CW'(1);
                                n_state = S_READ;
                            end
                        end
                        ACT_DUMP: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                            end else begin
                                re      = 1'b1;
                                n_left  = r_count - CW'(1);
                                n_off   = CW'(1);
                                n_state = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = r_rd_data;
                    n_out_has    = 1'b1;
                    n_out_status = ST_OK;
                    n_out_last   = (r_left == '0);
                    if (r_left != '0) begin
                        re     = 1'b1;
                        raddr  = slot(r_front, r_off);
                        n_off  = r_off + CW'(1);
                        n_left = r_left - CW'(1);
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_front      <= '0;
            r_count      <= '0;
            r_left       <= '0;
            r_off        <= '0;
            r_queue_mode <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_left      <= n_left;
            r_off       <= n_off;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_queue_mode <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_out_has    <= n_out_has;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    // element store, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= i_q.cmd.value;
        end
        if (re) begin
            r_rd_data <= r_mem[raddr];
        end
    end

    assign o_valid    = r_out_valid;
    assign o_data     = r_out_data;
    assign o_has_data = r_out_has;
    assign o_status   = r_out_status;
    assign o_last     = r_out_last;

endmodule

`default_nettype wire

/* design/stack_queue_buffer.sv */
// stack_queue_buffer: top level of the stack / queue buffer
// instantiates sqb_front and sqb_back; uses sqb_pkg
`default_nettype none

// Bounded store of up to DEPTH signed 32-bit values that works as a stack
// (cfg bit 0) or a queue (cfg bit 1). Input beats carry the action in tuser
// and the value in tdata; each beat gives one result beat, except a dump of
// a non-empty store, which gives one beat per element from front to back
// with tlast on the back element. Input beats land in a two-entry command
// queue, so input keeps flowing while the result register waits. The
// executor takes one command per cycle for push, pop and empty-store
// actions while the result register is free; peek and dump pass through a
// read state, as the element memory has a registered read port. The mode
// register must be written only while no command is pending or in progress.
module stack_queue_buffer #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,     // queue_mode
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // value[31:0]
    input  wire logic [1:0]  s_axis_tuser,   // action[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // data[31:0]
    output logic [2:0]       m_axis_tuser,   // has_data[0], status[2:1]
    output logic             m_axis_tlast    // last
);
    import sqb_pkg::*;

    t_cmd_q  q;
    logic    pop;
    logic    has_data;
    t_status status;

    assign o_cfg_ready = 1'b1;

    sqb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_action (s_axis_tuser),
        .i_value  (s_axis_tdata),
        .i_pop    (pop),
        .o_q      (q)
    );

    sqb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q         (q),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_has_data  (has_data),
        .o_status    (status),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tuser = {status, has_data};

endmodule

`default_nettype wire

/* design/sqb_checker.sv */
// sqb_checker: port-level assertions for stack_queue_buffer
// bound to the top level below; sees only its ports
`default_nettype none

module sqb_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // element beats always carry ok status
    a_has_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] == 2'd0)
        else $error("element beat with error status");

    // beats without an element carry zero data
    a_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
        else $error("nonzero data without element");

    // error status is a single-beat result and never the unused code
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2:1] != 2'd0
            |-> m_axis_tlast && m_axis_tuser[2:1] != 2'd3)
        else $error("bad error beat");

endmodule

bind stack_queue_buffer sqb_checker u_sqb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* tb/sv/stack_queue_buffer_test.sv */
`timescale 1ns / 1ps
// stack_queue_buffer_test: self-checking bench for the stack / queue buffer
// directed table then random push / pop / peek / dump runs in both modes;
// depends on sqb_pkg and stack_queue_buffer

module stack_queue_buffer_test;
    import sqb_pkg::*;

    localparam int unsigned DEPTH       = 64;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned CFG_SETTLE  = 8;
    localparam int unsigned TAIL_WAIT   = 80;
    localparam int unsigned HOLD_SPAN   = 300;
    localparam int unsigned PHASE_ITEMS = 44;

    typedef struct packed {
        logic signed [31:0] data;
        logic               has_data;
        t_status            status;
        logic               last;
    } t_result;

    typedef enum logic {
        K_OP   = 1'b0,
        K_MODE = 1'b1
    } t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_action     act;
        logic [31:0] val;
        bit          fixed;
        t_result     want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = ACT_PUSH;  // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;             // has_data[0], status[2:1]
    logic        m_axis_tlast;

    // shadow of the buffer
    logic [31:0] elems [DEPTH];
    logic [5:0]  front_ptr = '0;
    logic [6:0]  fill_count = '0;
    logic        queue_mode = 1'b0;

    t_result     due_beats [$];
    int unsigned errors = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_trigger = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;

    t_row plan [] = '{
        '{K_OP,   ACT_POP,  32'h0,        1'b1, '{32'h0,        1'b0, ST_EMPTY, 1'b1}},
        '{K_OP,   ACT_PEEK, 32'h0,        1'b1, '{32'h0,        1'b0, ST_EMPTY, 1'b1}},
        '{K_OP,   ACT_DUMP, 32'h0,        1'b1, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_OP,   ACT_PUSH, 32'h7fffffff, 1'b1, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_OP,   ACT_PUSH, 32'h80000000, 1'b1, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_OP,   ACT_PEEK, 32'h0,        1'b1, '{32'h80000000, 1'b1, ST_OK,    1'b1}},
        '{K_OP,   ACT_DUMP, 32'h0,        1'b0, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_OP,   ACT_PUSH, 32'h00000000, 1'b1, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_OP,   ACT_PUSH, 32'hffffffff, 1'b1, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_OP,   ACT_PEEK, 32'h0,        1'b1, '{32'hffffffff, 1'b1, ST_OK,    1'b1}},
        '{K_OP,   ACT_POP,  32'h0,        1'b1, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_OP,   ACT_PEEK, 32'h0,        1'b1, '{32'h00000000, 1'b1, ST_OK,    1'b1}},
        '{K_OP,   ACT_DUMP, 32'h0,        1'b0, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_OP,   ACT_POP,  32'h0,        1'b1, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_OP,   ACT_POP,  32'h0,        1'b1, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_OP,   ACT_POP,  32'h0,        1'b1, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_OP,   ACT_POP,  32'h0,        1'b1, '{32'h0,        1'b0, ST_EMPTY, 1'b1}},
        '{K_OP,   ACT_PUSH, 32'h5a5a5a5a, 1'b1, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_MODE, ACT_PUSH, 32'h1,        1'b0, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_OP,   ACT_PUSH, 32'h00000001, 1'b1, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_OP,   ACT_PUSH, 32'h00000002, 1'b1, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_OP,   ACT_PEEK, 32'h0,        1'b1, '{32'h5a5a5a5a, 1'b1, ST_OK,    1'b1}},
        '{K_OP,   ACT_DUMP, 32'h0,        1'b0, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_OP,   ACT_POP,  32'h0,        1'b1, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_OP,   ACT_POP,  32'h0,        1'b1, '{32'h0,        1'b0, ST_OK,    1'b1}},
        '{K_OP,   ACT_POP,  32'h0,        1'b1, '{32'h0,        1'b0, ST_OK,    1'b1}}
    };

    stack_queue_buffer #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    task automatic buffer_apply(input t_action act, input logic [31:0] val);
        int unsigned i;
        case (act)
            ACT_PUSH: begin
                if (fill_count >= DEPTH) begin
                    due_beats.push_back(t_result'{32'h0, 1'b0, ST_FULL, 1'b1});
                end else begin
                    if (queue_mode) begin
                        elems[6'(front_ptr + fill_count)] = val;
                    end else begin
                        front_ptr = front_ptr - 6'd1;
                        elems[front_ptr] = val;
                    end
                    fill_count = fill_count + 7'd1;
                    due_beats.push_back(t_result'{32'h0, 1'b0, ST_OK, 1'b1});
                end
            end
            ACT_POP: begin
                if (fill_count == 0) begin
                    due_beats.push_back(t_result'{32'h0, 1'b0, ST_EMPTY, 1'b1});
                end else begin
                    front_ptr = front_ptr + 6'd1;
                    fill_count = fill_count - 7'd1;
                    due_beats.push_back(t_result'{32'h0, 1'b0, ST_OK, 1'b1});
                end
            end
            ACT_PEEK: begin
                if (fill_count == 0)
                    due_beats.push_back(t_result'{32'h0, 1'b0, ST_EMPTY, 1'b1});
                else
                    due_beats.push_back(t_result'{elems[front_ptr], 1'b1, ST_OK, 1'b1});
            end
            default: begin
                if (fill_count == 0) begin
                    due_beats.push_back(t_result'{32'h0, 1'b0, ST_OK, 1'b1});
                end else begin
                    for (i = 0; i < fill_count; i++)
                        due_beats.push_back(t_result'{elems[6'(front_ptr + i)], 1'b1, ST_OK,
                                                      (i + 1 == fill_count)});
                end
            end
        endcase
    endtask

    task automatic offer_command(input t_action act, input logic [31:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= val;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        buffer_apply(act, val);
    endtask

    task automatic write_mode(input logic mode);
        s_axis_tvalid <= 1'b0;
        while (due_beats.size() != 0)
            @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        queue_mode = mode;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h00000000;
            3: return 32'hffffffff;
            default: return $urandom();
        endcase
    endfunction

    // result side: ready pattern and long hold-off
    always @(posedge i_clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_SPAN;
        end
        if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_beats.size() == 0) begin
                $display("%0t: unexpected result beat, data %h tuser %b last %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                errors++;
            end else begin
                want = due_beats.pop_front();
                if (m_axis_tdata !== want.data) begin
                    $display("%0t: data expected %h actual %h", $time, want.data, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser[0] !== want.has_data) begin
                    $display("%0t: has_data expected %b actual %b",
                             $time, want.has_data, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tuser[2:1] !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_axis_tuser[2:1]);
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last expected %b actual %b", $time, want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        int unsigned roll;
        int unsigned push_w;
        int unsigned pop_w;
        int unsigned peek_w;
        t_action     act;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 8;
        recv_stall_pct = 8;
        foreach (plan[r]) begin
            if (plan[r].kind == K_MODE) begin
                write_mode(plan[r].val[0]);
            end else begin
                offer_command(plan[r].act, plan[r].val);
                if (plan[r].fixed) begin
                    void'(due_beats.pop_back());
                    due_beats.push_back(plan[r].want);
                end
            end
        end

        for (int p = 0; p < 8; p++) begin
            write_mode(p[0] ^ p[1]);
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 83;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 83;
                end
                default: begin
                    send_idle_pct  = 8;
                    recv_stall_pct = 8;
                end
            endcase
            if (p == 4)
                hold_trigger = ~hold_trigger;
            if (p % 3 == 1) begin
                while (fill_count < DEPTH)
                    offer_command(ACT_PUSH, pick_value());
                repeat (4) offer_command(ACT_PUSH, pick_value());
            end
            if (p % 3 == 2) begin
                push_w = 20;
                pop_w  = 50;
                peek_w = 15;
            end else begin
                push_w = 40;
                pop_w  = 25;
                peek_w = 15;
            end
            repeat (PHASE_ITEMS) begin
                roll = $urandom_range(99);
                if (roll < push_w)
                    act = ACT_PUSH;
                else if (roll < push_w + pop_w)
                    act = ACT_POP;
                else if (roll < push_w + pop_w + peek_w)
                    act = ACT_PEEK;
                else
                    act = ACT_DUMP;
                offer_command(act, pick_value());
            end
        end

        s_axis_tvalid <= 1'b0;
        while (due_beats.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
